FILE: rtl/mrb_pkg.sv
package mrb_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int PAGE_ROWS        = 8;

    localparam int DATA_W      = 8;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int PAGE_W      = 3;
    localparam int BIT_W       = 3;
    localparam int X_W         = 8;
    localparam int BCOL_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam int RSP_QUEUE_DEPTH = 4;
    localparam int RSP_PTR_W       = 2;
    localparam int RSP_CNT_W       = 3;

    localparam logic [BIT_W-1:0] STEP_LAST = 3'd7;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_LEFT   = 3'd0,
        CFG_AREA_TOP    = 3'd1,
        CFG_AREA_RIGHT  = 3'd2,
        CFG_AREA_BOTTOM = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              is_read;
        logic              live;
        logic [DATA_W-1:0] src_byte;
        logic [PAGE_W-1:0] page;
        logic [X_W-1:0]    x;
        logic [BIT_W-1:0]  bit_sel;
        logic [7:0]        mask;
        logic              rd_ok;
        logic              area_done;
        logic              status;
    } job_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              area_done;
        logic              status;
    } rsp_t;

    typedef struct packed {
        logic finished;
    } walk_stat_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } eng_stat_t;

endpackage

FILE: rtl/mrb_if.sv
interface mrb_req_if import mrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DATA_W-1:0] src_byte;
    logic [PAGE_W-1:0] read_page;
    logic [COL_W-1:0]  read_column;

    modport source (output valid, cmd, src_byte, read_page, read_column, input ready);
    modport sink   (input valid, cmd, src_byte, read_page, read_column, output ready);
endinterface

interface mrb_rsp_if import mrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              area_done;
    logic              status;

    modport source (output valid, read_data, area_done, status, input ready);
    modport sink   (input valid, read_data, area_done, status, output ready);
endinterface

interface mrb_cfg_if import mrb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mrb_ram.sv
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mrb_walker.sv
module mrb_walker import mrb_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mrb_cfg_if.sink           cfg,
    input  logic              accept,
    input  logic              cmd,
    input  logic [DATA_W-1:0] src_byte,
    input  logic [PAGE_W-1:0] read_page,
    input  logic [COL_W-1:0]  read_column,
    output job_t              job,
    output walk_stat_t        stat
);

    localparam int PAGE_COUNT = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;

    logic [COL_W-1:0]  left_reg,   left_next;
    logic [ROW_W-1:0]  top_reg,    top_next;
    logic [COL_W-1:0]  right_reg,  right_next;
    logic [ROW_W-1:0]  bottom_reg, bottom_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [BCOL_W-1:0] bcol_reg,   bcol_next;
    logic              fin_reg,    fin_next;

    logic              cfg_fire;
    logic              is_read;
    logic              inverted;
    logic              ignore;
    logic [7:0]        width;
    logic [7:0]        width_up;
    logic [4:0]        row_bytes;
    logic [X_W-1:0]    base_x;
    logic [7:0]        xrel;
    logic [8:0]        xabs;
    logic [7:0]        mask;
    logic              row_in;
    logic [BCOL_W-1:0] bcol_inc;
    logic              wrap;
    logic              last_row;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        is_read   = (cmd == CMD_READ);
        inverted  = (right_reg < left_reg) || (bottom_reg < top_reg);
        ignore    = fin_reg || inverted;
        width     = {1'b0, right_reg} - {1'b0, left_reg} + 8'd1;
        width_up  = width + 8'd7;
        row_bytes = width_up[7:3];
        base_x    = {1'b0, left_reg} + {1'b0, bcol_reg, 3'b000};
        row_in    = {2'b00, row_reg} < 8'(PANEL_HEIGHT);
        mask      = '0;
        for (int b = 0; b < 8; b++)
        begin
            xrel    = {1'b0, bcol_reg, 3'b000} + 8'(b);
            xabs    = {1'b0, base_x} + 9'(b);
            mask[b] = (xrel < width) && (xabs < 9'(PANEL_WIDTH)) && row_in;
        end
        bcol_inc = bcol_reg + 4'd1;
        wrap     = ({1'b0, bcol_inc} >= row_bytes) || (bcol_inc == '0);
        last_row = row_reg >= bottom_reg;

        job.is_read   = is_read;
        job.live      = !is_read && !ignore;
        job.src_byte  = src_byte;
        job.page      = is_read ? read_page : row_reg[ROW_W-1:BIT_W];
        job.x         = is_read ? {1'b0, read_column} : base_x;
        job.bit_sel   = row_reg[BIT_W-1:0];
        job.mask      = mask;
        job.rd_ok     = ({2'b00, read_page} < 5'(PAGE_COUNT))
                        && ({2'b00, read_column} < 9'(PANEL_WIDTH));
        job.area_done = !is_read && !ignore && wrap && last_row;
        job.status    = !is_read && ignore;

        stat.finished = fin_reg;
    end

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        row_next    = row_reg;
        bcol_next   = bcol_reg;
        fin_next    = fin_reg;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_AREA_LEFT:
                begin
                    left_next = cfg.data[COL_W-1:0];
                    row_next  = top_reg;
                    bcol_next = '0;
                    fin_next  = 1'b0;
                end
                CFG_AREA_TOP:
                begin
                    top_next  = cfg.data[ROW_W-1:0];
                    row_next  = cfg.data[ROW_W-1:0];
                    bcol_next = '0;
                    fin_next  = 1'b0;
                end
                CFG_AREA_RIGHT:
                begin
                    right_next = cfg.data[COL_W-1:0];
                    row_next   = top_reg;
                    bcol_next  = '0;
                    fin_next   = 1'b0;
                end
                CFG_AREA_BOTTOM:
                begin
                    bottom_next = cfg.data[ROW_W-1:0];
                    row_next    = top_reg;
                    bcol_next   = '0;
                    fin_next    = 1'b0;
                end
                default:
                begin
                    fin_next = fin_reg;
                end
            endcase
        end
        else if (accept && job.live)
        begin
            if (wrap)
            begin
                bcol_next = '0;
                if (last_row)
                begin
                    fin_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 6'd1;
                end
            end
            else
            begin
                bcol_next = bcol_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= 7'd127;
            bottom_reg <= 6'd63;
            row_reg    <= '0;
            bcol_reg   <= '0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            row_reg    <= row_next;
            bcol_reg   <= bcol_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

FILE: rtl/mrb_rsp_queue.sv
module mrb_rsp_queue import mrb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rsp_t                 push_data,
    mrb_rsp_if.source            rsp,
    output logic [RSP_CNT_W-1:0] count
);

    rsp_t                 entry_reg [RSP_QUEUE_DEPTH];
    logic [RSP_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RSP_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RSP_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                 pop;
    rsp_t                 head;

    always_comb
    begin
        head          = entry_reg[rd_ptr_reg];
        rsp.valid     = (cnt_reg != '0);
        rsp.read_data = head.read_data;
        rsp.area_done = head.area_done;
        rsp.status    = head.status;
        pop           = rsp.valid && rsp.ready;
        count         = cnt_reg;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == RSP_PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RSP_PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mrb_engine.sv
module mrb_engine import mrb_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  job_t                 job,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  logic [RSP_CNT_W-1:0] q_count,
    output logic                 rsp_push,
    output rsp_t                 rsp_data,
    output eng_stat_t            stat
);

    localparam int PAGE_COUNT = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int DEPTH      = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W     = $clog2(DEPTH);

    job_t              job_reg;
    logic              job_vld_reg,  job_vld_next;
    logic [BIT_W-1:0]  step_reg,     step_next;
    logic              clr_reg,      clr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              s2_vld_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [BIT_W-1:0]  s2_bit_reg;
    logic              s2_on_reg;
    logic              s2_en_reg;
    logic              s2_last_reg;
    logic              s2_is_read_reg;
    logic              s2_rd_ok_reg;
    logic              s2_done_reg;
    logic              s2_status_reg;

    logic              wr_vld_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [DATA_W-1:0] wr_data_reg;

    logic              last_step;
    logic              room;
    logic              fire;
    logic [8:0]        x_sum;
    logic [11:0]       page_base;
    logic [11:0]       addr_full;
    logic [ADDR_W-1:0] rd_addr;
    logic              px_en;
    logic              px_on;

    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] cur_byte;
    logic [DATA_W-1:0] bit_mask;
    logic [DATA_W-1:0] upd_byte;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;

    always_comb
    begin
        last_step = job_reg.is_read || !job_reg.live || (step_reg == STEP_LAST);
        room      = ({1'b0, q_count} + {3'b000, s2_vld_reg && s2_last_reg})
                    < 4'(RSP_QUEUE_DEPTH);
        fire      = job_vld_reg && (!last_step || room);
        job_ready = !clr_reg && (!job_vld_reg || (fire && last_step));

        x_sum     = {1'b0, job_reg.x} + {6'b000000, step_reg};
        page_base = 12'(PANEL_WIDTH) * {9'b0, job_reg.page};
        addr_full = page_base + {3'b000, x_sum};
        rd_addr   = addr_full[ADDR_W-1:0];
        px_en     = job_reg.live && job_reg.mask[step_reg];
        px_on     = job_reg.src_byte[STEP_LAST - step_reg];

        job_vld_next = job_vld_reg;
        step_next    = step_reg;
        if (job_valid)
        begin
            job_vld_next = 1'b1;
            step_next    = '0;
        end
        else if (fire && last_step)
        begin
            job_vld_next = 1'b0;
        end
        else if (fire)
        begin
            step_next = step_reg + 1'b1;
        end

        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        cur_byte = (wr_vld_reg && (wr_addr_reg == s2_addr_reg)) ? wr_data_reg : ram_rdata;
        bit_mask = DATA_W'(1) << s2_bit_reg;
        upd_byte = s2_on_reg ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
        we       = clr_reg || (s2_vld_reg && s2_en_reg);
        waddr    = clr_reg ? clr_addr_reg : s2_addr_reg;
        wdata    = clr_reg ? '0 : upd_byte;

        rsp_push           = s2_vld_reg && s2_last_reg;
        rsp_data.read_data = (s2_is_read_reg && s2_rd_ok_reg) ? cur_byte : '0;
        rsp_data.area_done = s2_done_reg;
        rsp_data.status    = s2_status_reg;

        stat.clearing = clr_reg;
        stat.busy     = job_vld_reg || s2_vld_reg;
    end

    mrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_vld_reg  <= 1'b0;
            step_reg     <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            s2_vld_reg   <= 1'b0;
            wr_vld_reg   <= 1'b0;
        end
        else
        begin
            job_vld_reg  <= job_vld_next;
            step_reg     <= step_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            s2_vld_reg   <= fire;
            wr_vld_reg   <= we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            job_reg <= job;
        end
        if (fire)
        begin
            s2_addr_reg    <= rd_addr;
            s2_bit_reg     <= job_reg.bit_sel;
            s2_on_reg      <= px_on;
            s2_en_reg      <= px_en;
            s2_last_reg    <= last_step;
            s2_is_read_reg <= job_reg.is_read;
            s2_rd_ok_reg   <= job_reg.rd_ok;
            s2_done_reg    <= job_reg.area_done;
            s2_status_reg  <= job_reg.status;
        end
        wr_addr_reg <= waddr;
        wr_data_reg <= wdata;
    end

endmodule

FILE: rtl/mono_row_bitmap_to_page_columns.sv
// Converts a row-major 1-bit bitmap into a page/column panel frame store.
// A load beat takes eight source pixels of the current area row and writes
// them one pixel per cycle, the last one waiting while the 4-entry result
// queue has no room, as read-modify-writes of the frame store RAM; a read beat,
// or a load that is ignored because the area is complete or inverted, is a
// single store access. The next beat is taken in the cycle the previous one
// issues its last store access; its result is registered in the s2 stage and
// then in the result queue before it appears on rsp. After reset the store
// is cleared one byte per cycle, PAGE_COUNT * PANEL_WIDTH bytes (1024 at the
// default size), with req.ready low; configuration writes are taken at any
// time. Any register write restarts the walk at the area's top-left byte.
module mono_row_bitmap_to_page_columns import mrb_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mrb_cfg_if.sink   cfg,
    mrb_req_if.sink   req,
    mrb_rsp_if.source rsp
);

    logic                 req_fire;
    logic                 job_ready;
    job_t                 job;
    walk_stat_t           walk_stat;
    eng_stat_t            eng_stat;
    logic                 rsp_push;
    rsp_t                 rsp_data;
    logic [RSP_CNT_W-1:0] q_count;

    assign req.ready = job_ready;
    assign req_fire  = req.valid && req.ready;

    mrb_walker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (req_fire),
        .cmd         (req.cmd),
        .src_byte    (req.src_byte),
        .read_page   (req.read_page),
        .read_column (req.read_column),
        .job         (job),
        .stat        (walk_stat)
    );

    mrb_engine #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (req_fire),
        .job_ready (job_ready),
        .q_count   (q_count),
        .rsp_push  (rsp_push),
        .rsp_data  (rsp_data),
        .stat      (eng_stat)
    );

    mrb_rsp_queue u_rsp_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rsp_push),
        .push_data (rsp_data),
        .rsp       (rsp),
        .count     (q_count)
    );

`ifndef SYNTHESIS
    a_no_beat_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        eng_stat.clearing |-> !req_fire
    ) else $error("request beat taken during store clear");

    a_done_excludes_ignored: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.area_done && rsp.status)
    ) else $error("result flags both done and ignored");

    a_finished_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_fire && (req.cmd == CMD_LOAD) && walk_stat.finished
            && !(cfg.valid && cfg.ready)) |=> walk_stat.finished
    ) else $error("ignored load changed the walk");

    a_clear_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        eng_stat.clearing |-> !eng_stat.busy && (q_count == '0)
    ) else $error("store work pending during clear");
`endif

endmodule

FILE: verif/mono_row_bitmap_to_page_columns_tb.sv
`timescale 1ns / 100ps

module mono_row_bitmap_to_page_columns_tb import mrb_pkg::*; ();

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 900;

    class page_store_scoreboard;
        logic [7:0] pixels [PAGE_ROWS * PANEL_WIDTH_DEF];
        logic [ROW_W-1:0]  walk_row;
        logic [BCOL_W-1:0] walk_col_byte;
        logic              walk_done;
        logic [COL_W-1:0]  win_left;
        logic [ROW_W-1:0]  win_top;
        logic [COL_W-1:0]  win_right;
        logic [ROW_W-1:0]  win_bottom;
        rsp_t              pending_replies [$];
        int                mismatches;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = '0;
            end
            win_left      = '0;
            win_top       = '0;
            win_right     = 7'd127;
            win_bottom    = 6'd63;
            walk_row      = '0;
            walk_col_byte = '0;
            walk_done     = 1'b0;
            mismatches    = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void apply_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_AREA_LEFT:   win_left   = val[COL_W-1:0];
                CFG_AREA_TOP:    win_top    = val[ROW_W-1:0];
                CFG_AREA_RIGHT:  win_right  = val[COL_W-1:0];
                CFG_AREA_BOTTOM: win_bottom = val[ROW_W-1:0];
                default:         return;
            endcase
            walk_row      = win_top;
            walk_col_byte = '0;
            walk_done     = 1'b0;
        endfunction

        function void note_request(cmd_t cmd, logic [7:0] src, logic [2:0] page,
                                   logic [6:0] col);
            rsp_t reply;
            int   width;
            int   row_bytes;
            int   xrel;
            int   x;
            int   idx;
            int   b;
            reply = '0;
            if (cmd == CMD_READ)
            begin
                reply.read_data = pixels[{page, col}];
            end
            else if (walk_done || win_right < win_left || win_bottom < win_top)
            begin
                reply.status = 1'b1;
            end
            else
            begin
                width     = int'(win_right) - int'(win_left) + 1;
                row_bytes = (width + 7) / 8;
                for (b = 0; b < 8; b++)
                begin
                    xrel = int'(walk_col_byte) * 8 + b;
                    x    = int'(win_left) + xrel;
                    if (xrel < width && x < PANEL_WIDTH_DEF && walk_row < PANEL_HEIGHT_DEF)
                    begin
                        idx = int'(walk_row[5:3]) * PANEL_WIDTH_DEF + x;
                        pixels[idx][walk_row[2:0]] = src[7 - b];
                    end
                end
                walk_col_byte = walk_col_byte + 1'b1;
                if (int'(walk_col_byte) >= row_bytes || walk_col_byte == '0)
                begin
                    walk_col_byte = '0;
                    if (walk_row >= win_bottom)
                    begin
                        walk_done       = 1'b1;
                        reply.area_done = 1'b1;
                    end
                    else
                    begin
                        walk_row = walk_row + 1'b1;
                    end
                end
            end
            pending_replies.push_back(reply);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_reply(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                report($sformatf("unexpected reply %h", got));
                return;
            end
            want = pending_replies.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
            if (got.area_done !== want.area_done)
                report($sformatf("area_done got %b want %b", got.area_done, want.area_done));
            if (got.status !== want.status)
                report($sformatf("status got %b want %b", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   hold_requests = 0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;
    int   area_l = 0;
    int   area_t = 0;
    int   area_r = 127;
    int   area_b = 63;

    page_store_scoreboard sb = new();

    mrb_cfg_if cfg_if ();
    mrb_req_if req_if ();
    mrb_rsp_if rsp_if ();

    mono_row_bitmap_to_page_columns u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            sb.check_reply({rsp_if.read_data, rsp_if.area_done, rsp_if.status});
    end

    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int holds_seen;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_seen = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= (cycle_count % 5 != 0);
                endcase
            end
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic send(cmd_t cmd, logic [7:0] src, logic [2:0] page, logic [6:0] col);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 12);
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.src_byte    <= src;
        req_if.read_page   <= page;
        req_if.read_column <= col;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_request(cmd, src, page, col);
    endtask

    task automatic load(logic [7:0] src);
        send(CMD_LOAD, src, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
    endtask

    task automatic read_at(int page, int col);
        send(CMD_READ, 8'($urandom_range(0, 255)), 3'(page), 7'(col));
    endtask

    task automatic read_rand();
        int row;
        int col;
        if (area_l <= area_r && area_t <= area_b && $urandom_range(0, 3) != 0)
        begin
            row = $urandom_range(area_t, area_b);
            col = $urandom_range(area_l, area_r);
        end
        else
        begin
            row = $urandom_range(0, 63);
            col = $urandom_range(0, 127);
        end
        read_at(row / 8, col);
    endtask

    function automatic logic [7:0] rand_src();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic cfg_write(cfg_idx_t idx, int val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= 8'(val);
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.apply_cfg(idx, 8'(val));
    endtask

    task automatic set_area(int l, int t, int r, int b);
        req_if.valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        cfg_write(CFG_AREA_LEFT, l);
        cfg_write(CFG_AREA_TOP, t);
        cfg_write(CFG_AREA_RIGHT, r);
        cfg_write(CFG_AREA_BOTTOM, b);
        cfg_if.valid <= 1'b0;
        area_l = l;
        area_t = t;
        area_r = r;
        area_b = b;
    endtask

    initial
    begin
        int items;
        int phase;
        int kind;
        int l;
        int t;
        int r;
        int b;
        int w;
        int h;
        int loads_needed;
        int n_loads;
        int i;
        items = 0;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= CMD_LOAD;
        req_if.src_byte    <= '0;
        req_if.read_page   <= '0;
        req_if.read_column <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_AREA_LEFT;
        cfg_if.data        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // full panel after reset: cleared store, first bytes of row 0
        read_at(0, 0);
        load(8'hA5);
        load(8'hFF);
        read_at(0, 0);
        read_at(0, 8);
        read_at(7, 127);

        // unaligned narrow area at the panel bottom, padding bits dropped
        set_area(3, 62, 5, 63);
        load(8'hFF);
        load(8'h40);
        load(8'h80);
        read_at(7, 3);
        read_at(7, 4);
        read_at(7, 6);

        // inverted columns, then inverted rows
        set_area(10, 0, 9, 0);
        load(8'hFF);
        set_area(0, 5, 10, 4);
        load(8'hFF);

        // single pixel area
        set_area(0, 0, 0, 0);
        load(8'h7F);
        load(8'hFF);
        read_at(0, 0);

        // right panel edge
        set_area(121, 0, 127, 0);
        load(8'hFF);
        read_at(0, 127);
        items = 20;

        phase = 0;
        while (items < ITEM_TARGET)
        begin
            kind = (phase == 0) ? 1 : $urandom_range(0, 9);
            if (kind == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    l = $urandom_range(1, 127);
                    r = $urandom_range(0, l - 1);
                    t = $urandom_range(0, 63);
                    b = $urandom_range(t, 63);
                end
                else
                begin
                    t = $urandom_range(1, 63);
                    b = $urandom_range(0, t - 1);
                    l = $urandom_range(0, 127);
                    r = $urandom_range(l, 127);
                end
                loads_needed = 0;
                n_loads = $urandom_range(1, 3);
            end
            else
            begin
                if (kind == 1)
                begin
                    w = $urandom_range(64, 128);
                    h = (phase == 0) ? 3 : $urandom_range(1, 3);
                end
                else if (kind == 2)
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(32, 64);
                end
                else
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 6);
                end
                case ($urandom_range(0, 4))
                    0:       l = 0;
                    1:       l = 128 - w;
                    default: l = $urandom_range(0, 128 - w);
                endcase
                case ($urandom_range(0, 4))
                    0:       t = 0;
                    1:       t = 64 - h;
                    default: t = $urandom_range(0, 64 - h);
                endcase
                r = l + w - 1;
                b = t + h - 1;
                loads_needed = ((w + 7) / 8) * h;
                if (loads_needed > 1 && $urandom_range(0, 3) == 0)
                    n_loads = $urandom_range(1, loads_needed - 1);
                else
                    n_loads = loads_needed + $urandom_range(0, 2);
            end
            set_area(l, t, r, b);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 7) == 0)
            begin
                gaps_on = 1'b0;
                hold_requests++;
            end
            for (i = 0; i < n_loads; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    read_rand();
                    items++;
                end
                load(rand_src());
                if (i < loads_needed)
                    items++;
            end
            for (i = $urandom_range(2, 6); i > 0; i--)
            begin
                read_rand();
                items++;
            end
            phase++;
        end

        req_if.valid <= 1'b0;
        wait_drained();
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mrb_pkg.sv
rtl/mrb_if.sv
rtl/mrb_ram.sv
rtl/mrb_walker.sv
rtl/mrb_rsp_queue.sv
rtl/mrb_engine.sv
rtl/mono_row_bitmap_to_page_columns.sv
verif/mono_row_bitmap_to_page_columns_tb.sv
